// File: rtl/mcfir_pkg.sv
// shared types and constants of the multichannel fir filter
// no dependencies; used by mcfir_mac and multichannel_fir_filter
package mcfir_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int PROD_W            = 2 * SAMPLE_W;
    localparam int Q15_SHIFT         = 15;
    localparam int NUM_SAMPLE_FIELDS = 4;

    // command codes carried in s_axis_tuser
    localparam int              CMD_W      = 2;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // input beat layout
    localparam int CHAN_FIELD_W = 2;
    localparam int TAP_FIELD_W  = 5;
    localparam int CHAN_LSB     = NUM_SAMPLE_FIELDS * SAMPLE_W;
    localparam int TAP_LSB      = CHAN_LSB + CHAN_FIELD_W;
    localparam int WEIGHT_LSB   = TAP_LSB + TAP_FIELD_W;
    localparam int S_TDATA_W    = 88;
    localparam int S_TUSER_W    = CMD_W;

    // result beat layout
    localparam int RAW_LSB   = 0;
    localparam int FILT_LSB  = SAMPLE_W;
    localparam int M_TDATA_W = 2 * SAMPLE_W;

    // control that travels with each tap through the mac pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mcfir_mac_ctrl_t;

endpackage

// File: rtl/mcfir_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies; holds the sample rows and the tap weights
module mcfir_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mcfir_mac.sv
// shared multiply-accumulate with q15 scaling and 16-bit saturation
// depends on mcfir_pkg for widths and the pipeline control struct
module mcfir_mac #(
    parameter int TAPS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mcfir_pkg::mcfir_mac_ctrl_t          ctrl_i,
    input  logic signed [mcfir_pkg::SAMPLE_W-1:0] weight_i,
    input  logic signed [mcfir_pkg::SAMPLE_W-1:0] sample_i,
    output logic                                done_o,
    output logic signed [mcfir_pkg::SAMPLE_W-1:0] result_o
);

    localparam int ACC_W = mcfir_pkg::PROD_W + $clog2(TAPS);
    localparam int Q_W   = ACC_W - mcfir_pkg::Q15_SHIFT;
    localparam logic signed [Q_W-1:0] Q_MAX =
        {{(Q_W - mcfir_pkg::Q15_SHIFT){1'b0}}, {mcfir_pkg::Q15_SHIFT{1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN =
        {{(Q_W - mcfir_pkg::Q15_SHIFT){1'b1}}, {mcfir_pkg::Q15_SHIFT{1'b0}}};

    mcfir_pkg::mcfir_mac_ctrl_t           p_ctrl_reg;
    logic signed [mcfir_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]              acc_reg;
    logic signed [ACC_W-1:0]              acc_next;
    logic                                 fin_reg;
    logic signed [Q_W-1:0]                q_reg;
    logic signed [Q_W-1:0]                q_next;
    logic [ACC_W-1:0]                     biased;
    logic                                 qv_reg;
    logic signed [mcfir_pkg::SAMPLE_W-1:0] result_reg;
    logic signed [mcfir_pkg::SAMPLE_W-1:0] result_next;
    logic                                 done_reg;

    always_comb begin
        acc_next = (p_ctrl_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
        // bias negative sums so the shift truncates toward zero
        biased   = acc_reg + (acc_reg[ACC_W-1] ?
                   ACC_W'((1 << mcfir_pkg::Q15_SHIFT) - 1) : '0);
        q_next   = biased[ACC_W-1:mcfir_pkg::Q15_SHIFT];
        if (q_reg > Q_MAX) begin
            result_next = Q_MAX[mcfir_pkg::SAMPLE_W-1:0];
        end else if (q_reg < Q_MIN) begin
            result_next = Q_MIN[mcfir_pkg::SAMPLE_W-1:0];
        end else begin
            result_next = q_reg[mcfir_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ctrl_reg <= '0;
            fin_reg    <= 1'b0;
            qv_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            p_ctrl_reg <= ctrl_i;
            fin_reg    <= p_ctrl_reg.valid && p_ctrl_reg.last;
            qv_reg     <= fin_reg;
            done_reg   <= qv_reg;
        end
        prod_reg <= weight_i * sample_i;
        if (p_ctrl_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (fin_reg) begin
            q_reg <= q_next;
        end
        if (qv_reg) begin
            result_reg <= result_next;
        end
    end

    assign done_o   = done_reg;
    assign result_o = result_reg;

endmodule

// File: rtl/multichannel_fir_filter.sv
// top level of the multichannel fir filter: command decode, memory sequencer, result register
// depends on mcfir_pkg, mcfir_ram and mcfir_mac
//
//   channel   dir   beat contents
//   s_axis    in    tuser: cmd; tdata: sample_ch0..3, channel, tap_index, weight_value
//   m_axis    out   tdata: raw_value, filtered_value (one beat per read command)
//
// sample and weight beats write the memories on the accept edge
// a read walks all TAPS taps through one multiplier, one ram read each
// after reset a clearing pass zeroes both memories, tready low
// a finished result waits in the output register; sample and weight beats are still taken
// a new read can run meanwhile and holds its result until the output register frees
module multichannel_fir_filter #(
    parameter int TAPS     = 32,
    parameter int CHANNELS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // lsb up: sample_ch0, sample_ch1, sample_ch2, sample_ch3, channel, tap_index, weight_value
    input  logic [mcfir_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [mcfir_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // lsb up: raw_value, filtered_value
    output logic [mcfir_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int SW     = mcfir_pkg::SAMPLE_W;
    localparam int TA_W   = $clog2(TAPS);
    localparam int IDX_W  = $clog2(TAPS + 1);
    localparam int WDEPTH = CHANNELS * TAPS;
    localparam int WA_W   = $clog2(WDEPTH);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROW_W  = CHANNELS * SW;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_HOLD
    } state_t;

    state_t                      state_reg, state_next;
    logic [WA_W-1:0]             clr_reg, clr_next;
    logic [TA_W-1:0]             wp_reg, wp_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [TA_W-1:0]             slot_reg, slot_next;
    logic [CH_W-1:0]             ch_reg, ch_next;
    logic                        oor_reg, oor_next;
    mcfir_pkg::mcfir_mac_ctrl_t  ctrl_issue, ctrl_d1_reg;
    logic                        raw_issue, raw_d1_reg;
    logic [SW-1:0]               raw_reg, raw_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SW-1:0]               out_raw_reg, out_raw_next;
    logic [SW-1:0]               out_filt_reg, out_filt_next;

    // beat fields
    logic [mcfir_pkg::CMD_W-1:0]        cmd;
    logic [SW-1:0]                      samp [mcfir_pkg::NUM_SAMPLE_FIELDS];
    logic [mcfir_pkg::CHAN_FIELD_W-1:0] ch_field;
    logic [mcfir_pkg::TAP_FIELD_W-1:0]  tap_field;
    logic [SW-1:0]                      weight_field;

    logic              s_fire;
    logic              clearing;
    logic              ch_ok, tap_ok;
    logic [CH_W-1:0]   ch_eff;
    logic [TA_W-1:0]   newest;
    logic              last_step;
    logic [TA_W-1:0]   tap_k;
    logic [ROW_W-1:0]  row_wdata;

    logic              s_we, s_re;
    logic [TA_W-1:0]   s_waddr, s_raddr;
    logic [ROW_W-1:0]  s_wdata, s_rdata;
    logic              w_we, w_re;
    logic [WA_W-1:0]   w_waddr, w_raddr;
    logic [SW-1:0]     w_wdata, w_rdata;
    logic [SW-1:0]     lane;
    logic              mac_done;
    logic [SW-1:0]     mac_result;

    always_comb begin
        cmd = s_axis_tuser;
        for (int i = 0; i < mcfir_pkg::NUM_SAMPLE_FIELDS; i++) begin
            samp[i] = s_axis_tdata[i*SW +: SW];
        end
        ch_field     = s_axis_tdata[mcfir_pkg::CHAN_LSB +: mcfir_pkg::CHAN_FIELD_W];
        tap_field    = s_axis_tdata[mcfir_pkg::TAP_LSB +: mcfir_pkg::TAP_FIELD_W];
        weight_field = s_axis_tdata[mcfir_pkg::WEIGHT_LSB +: SW];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign clearing      = (state_reg == ST_CLEAR);
    assign ch_ok         = 32'(ch_field) < CHANNELS;
    assign tap_ok        = 32'(tap_field) < TAPS;
    assign ch_eff        = ch_ok ? CH_W'(ch_field) : '0;
    assign newest        = (wp_reg == '0) ? TA_W'(TAPS - 1) : wp_reg - 1'b1;
    assign last_step     = (idx_reg == IDX_W'(TAPS));
    assign tap_k         = last_step ? '0 : idx_reg[TA_W-1:0];

    // channels beyond the four sample fields get zero
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            row_wdata[c*SW +: SW] = (c < mcfir_pkg::NUM_SAMPLE_FIELDS) ? samp[2'(c)] : '0;
        end
    end

    // memory ports
    always_comb begin
        s_we    = clearing ? (32'(clr_reg) < TAPS) : (s_fire && cmd == mcfir_pkg::CMD_SAMPLE);
        s_waddr = clearing ? TA_W'(clr_reg) : wp_reg;
        s_wdata = clearing ? '0 : row_wdata;
        s_re    = (state_reg == ST_RUN);
        s_raddr = last_step ? newest : slot_reg;

        w_we    = clearing ||
                  (s_fire && cmd == mcfir_pkg::CMD_WEIGHT && ch_ok && tap_ok);
        w_waddr = clearing ? clr_reg : WA_W'(32'(ch_eff) * TAPS + 32'(tap_field));
        w_wdata = clearing ? '0 : weight_field;
        w_re    = (state_reg == ST_RUN);
        w_raddr = WA_W'(32'(ch_reg) * TAPS + 32'(tap_k));
    end

    mcfir_ram #(
        .DEPTH (TAPS),
        .WIDTH (ROW_W)
    ) u_sample_ram (
        .aclk    (aclk),
        .wr_en   (s_we),
        .wr_addr (s_waddr),
        .wr_data (s_wdata),
        .rd_en   (s_re),
        .rd_addr (s_raddr),
        .rd_data (s_rdata)
    );

    mcfir_ram #(
        .DEPTH (WDEPTH),
        .WIDTH (SW)
    ) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (w_we),
        .wr_addr (w_waddr),
        .wr_data (w_wdata),
        .rd_en   (w_re),
        .rd_addr (w_raddr),
        .rd_data (w_rdata)
    );

    assign lane = s_rdata[ch_reg*SW +: SW];

    always_comb begin
        ctrl_issue.valid = (state_reg == ST_RUN) && !last_step;
        ctrl_issue.first = (idx_reg == '0);
        ctrl_issue.last  = (idx_reg == IDX_W'(TAPS - 1));
        raw_issue        = (state_reg == ST_RUN) && last_step;
    end

    mcfir_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_i   (ctrl_d1_reg),
        .weight_i (w_rdata),
        .sample_i (lane),
        .done_o   (mac_done),
        .result_o (mac_result)
    );

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wp_next        = wp_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        ch_next        = ch_reg;
        oor_next       = oor_reg;
        raw_next       = raw_d1_reg ? lane : raw_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_raw_next   = out_raw_reg;
        out_filt_next  = out_filt_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == WA_W'(WDEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (cmd == mcfir_pkg::CMD_SAMPLE) begin
                        wp_next = (wp_reg == TA_W'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
                    end else if (cmd == mcfir_pkg::CMD_READ) begin
                        idx_next   = '0;
                        slot_next  = wp_reg;
                        ch_next    = ch_eff;
                        oor_next   = !ch_ok;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                idx_next  = idx_reg + 1'b1;
                slot_next = (slot_reg == TA_W'(TAPS - 1)) ? '0 : slot_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_raw_next   = oor_reg ? '0 : raw_reg;
                    out_filt_next  = oor_reg ? '0 : mac_result;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            idx_reg       <= '0;
            slot_reg      <= '0;
            ch_reg        <= '0;
            oor_reg       <= 1'b0;
            ctrl_d1_reg   <= '0;
            raw_d1_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wp_reg        <= wp_next;
            idx_reg       <= idx_next;
            slot_reg      <= slot_next;
            ch_reg        <= ch_next;
            oor_reg       <= oor_next;
            ctrl_d1_reg   <= ctrl_issue;
            raw_d1_reg    <= raw_issue;
            out_valid_reg <= out_valid_next;
        end
        raw_reg      <= raw_next;
        out_raw_reg  <= out_raw_next;
        out_filt_reg <= out_filt_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_filt_reg, out_raw_reg};

endmodule
